/* hw/rtl/fisr_pkg.sv */
// fisr_pkg: constants, pipeline control type and shared binary32 helper functions
// for the reciprocal square root pipeline; depends on nothing
package fisr_pkg;

  localparam logic [31:0] QNAN_BITS      = 32'h7fc0_0000;
  localparam logic [31:0] INF_BITS       = 32'h7f80_0000;
  localparam logic [31:0] SEED_MAGIC     = 32'h5f37_59df;
  localparam logic [31:0] HALF_BITS      = 32'h3f00_0000;
  localparam logic [31:0] THREEHALF_BITS = 32'h3fc0_0000;

  localparam int MUL_LAT = 3;
  localparam int ADD_LAT = 4;

  typedef logic signed [11:0] exp_t;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  function automatic logic is_nan(input logic [31:0] a);
    return a[30:0] > INF_BITS[30:0];
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return a[30:0] == INF_BITS[30:0];
  endfunction

  function automatic logic is_zero(input logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] unpack_sig(input logic [31:0] a);
    return (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
  endfunction

  function automatic exp_t unpack_exp(input logic [31:0] a);
    return (a[30:23] == 8'd0) ? -12'sd149 : exp_t'({4'd0, a[30:23]}) - 12'sd150;
  endfunction

  function automatic logic [5:0] msb_pos(input logic [62:0] sig);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 63; i++) begin
      if (sig[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic logic [31:0] round_pack(input logic sign, input exp_t e,
                                             input logic [62:0] sig);
    exp_t        shw;
    logic [5:0]  sh;
    logic [62:0] m;
    logic [62:0] below;
    logic        g;
    logic        st;
    logic [31:0] bits;
    logic [31:0] res;
    shw   = (e >= 12'sd1) ? 12'sd39 : 12'sd40 - e;
    sh    = shw[5:0];
    m     = 63'd0;
    g     = 1'b0;
    st    = 1'b0;
    below = 63'd0;
    bits  = 32'd0;
    if (e >= 12'sd255) begin
      res = {sign, INF_BITS[30:0]};
    end else begin
      if (shw < 12'sd64) begin
        m     = sig >> sh;
        g     = sig[sh - 6'd1];
        below = (63'd1 << (sh - 6'd1)) - 63'd1;
        st    = |(sig & below);
        if (g && (st || m[0])) m = m + 63'd1;
      end
      if (e >= 12'sd1) bits = ({20'd0, e} - 32'd1) << 23;
      bits = bits + m[31:0];
      if (bits >= INF_BITS) res = {sign, INF_BITS[30:0]};
      else res = {sign, bits[30:0]};
    end
    return res;
  endfunction

endpackage

/* hw/rtl/fisr_if.sv */
// fisr_if: valid/ready stream interfaces for operand and result beats
// depends on nothing
interface fisr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_bits;
  modport source(output valid, output x_bits, input ready);
  modport sink(input valid, input x_bits, output ready);
endinterface

interface fisr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  modport source(output valid, output result_bits, input ready);
  modport sink(input valid, input result_bits, output ready);
endinterface

/* hw/rtl/fisr_fmul.sv */
// fisr_fmul: three stage binary32 multiplier, round to nearest even, subnormals kept
// depends on fisr_pkg
module fisr_fmul import fisr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pipe_ctl_t   ctl,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        valid,
  output logic [31:0] res
);

  logic        s0_spec;
  logic [31:0] s0_sres;
  logic        s0_sign;

  logic        v1, spec1, sign1;
  logic [31:0] sres1;
  exp_t        ex1;
  logic [47:0] prod1;

  logic        v2, spec2, sign2;
  logic [31:0] sres2;
  exp_t        e2;
  logic [62:0] sig2;

  logic [62:0] wide1;
  logic [5:0]  p1;

  always_comb begin
    s0_sign = a[31] ^ b[31];
    s0_spec = 1'b1;
    s0_sres = {s0_sign, 31'd0};
    if (is_nan(a) || is_nan(b)) begin
      s0_sres = QNAN_BITS;
    end else if (is_inf(a) || is_inf(b)) begin
      s0_sres = (is_zero(a) || is_zero(b)) ? QNAN_BITS : {s0_sign, INF_BITS[30:0]};
    end else if (is_zero(a) || is_zero(b)) begin
      s0_sres = {s0_sign, 31'd0};
    end else begin
      s0_spec = 1'b0;
    end
  end

  assign wide1 = {15'd0, prod1};
  assign p1    = msb_pos(wide1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else if (ctl.en) begin
      v1    <= ctl.valid;
      v2    <= v1;
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      spec1 <= s0_spec;
      sres1 <= s0_sres;
      sign1 <= s0_sign;
      ex1   <= unpack_exp(a) + unpack_exp(b);
      prod1 <= unpack_sig(a) * unpack_sig(b);
      spec2 <= spec1;
      sres2 <= sres1;
      sign2 <= sign1;
      sig2  <= wide1 << (6'd62 - p1);
      e2    <= ex1 + exp_t'({6'd0, p1}) + 12'sd127;
      res   <= spec2 ? sres2 : round_pack(sign2, e2, sig2);
    end
  end

endmodule

/* hw/rtl/fisr_fadd.sv */
// fisr_fadd: four stage binary32 adder, round to nearest even, subnormals kept
// depends on fisr_pkg
module fisr_fadd import fisr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pipe_ctl_t   ctl,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        valid,
  output logic [31:0] res
);

  logic        s0_spec;
  logic [31:0] s0_sres;
  logic [31:0] big, sml;
  exp_t        eb0, es0, d0;
  logic [61:0] sa0, sbw0, sb0;

  logic        v1, spec1, sub1, sign1;
  logic [31:0] sres1;
  exp_t        e1;
  logic [61:0] sa1, sb1;

  logic        v2, spec2, sign2;
  logic [31:0] sres2;
  exp_t        e2;
  logic [62:0] sum2;
  logic [62:0] sum1;

  logic        v3, spec3, sign3;
  logic [31:0] sres3;
  exp_t        e3;
  logic [62:0] sig3;
  logic [5:0]  p2;

  always_comb begin
    s0_spec = 1'b1;
    s0_sres = 32'd0;
    if (is_nan(a) || is_nan(b)) begin
      s0_sres = QNAN_BITS;
    end else if (is_inf(a) && is_inf(b)) begin
      s0_sres = (a == b) ? a : QNAN_BITS;
    end else if (is_inf(a)) begin
      s0_sres = a;
    end else if (is_inf(b)) begin
      s0_sres = b;
    end else if (is_zero(a) && is_zero(b)) begin
      s0_sres = {a[31] & b[31], 31'd0};
    end else if (is_zero(a)) begin
      s0_sres = b;
    end else if (is_zero(b)) begin
      s0_sres = a;
    end else begin
      s0_spec = 1'b0;
    end
    if (b[30:0] > a[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    eb0  = unpack_exp(big);
    es0  = unpack_exp(sml);
    d0   = eb0 - es0;
    sa0  = {38'd0, unpack_sig(big)} << 38;
    sbw0 = {38'd0, unpack_sig(sml)} << 38;
    if (d0 >= 12'sd62) begin
      sb0 = 62'd1;
    end else begin
      sb0 = (sbw0 >> d0[5:0]) | {61'd0, |(sbw0 & ((62'd1 << d0[5:0]) - 62'd1))};
    end
  end

  assign sum1 = sub1 ? {1'b0, sa1} - {1'b0, sb1} : {1'b0, sa1} + {1'b0, sb1};
  assign p2   = msb_pos(sum2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else if (ctl.en) begin
      v1    <= ctl.valid;
      v2    <= v1;
      v3    <= v2;
      valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      spec1 <= s0_spec;
      sres1 <= s0_sres;
      sub1  <= big[31] ^ sml[31];
      sign1 <= big[31];
      e1    <= eb0;
      sa1   <= sa0;
      sb1   <= sb0;
      spec2 <= spec1 || (sub1 && sum1 == 63'd0);
      sres2 <= spec1 ? sres1 : 32'd0;
      sign2 <= sign1;
      e2    <= e1;
      sum2  <= sum1;
      spec3 <= spec2;
      sres3 <= sres2;
      sign3 <= sign2;
      sig3  <= sum2 << (6'd62 - p2);
      e3    <= e2 + exp_t'({6'd0, p2}) + 12'sd89;
      res   <= spec3 ? sres3 : round_pack(sign3, e3, sig3);
    end
  end

endmodule

/* hw/rtl/fast_inverse_sqrt_float32_unit.sv */
// fast_inverse_sqrt_float32_unit: seed plus one newton step for 1/sqrt(x) in binary32
// depends on fisr_pkg, fisr_if, fisr_fmul, fisr_fadd
//
//   port      dir   beat
//   operand   sink  x_bits      (32 bit binary32 pattern)
//   result    src   result_bits (32 bit binary32 pattern)
//
// pipeline: four 3 stage multipliers, one 4 stage adder and the output register
// one beat accepted per cycle while the skid is empty; results leave through an output register plus skid
// the pipeline halts only when the skid holds a beat; no beat is lost or repeated
// synchronous active high reset clears valid bits only
module fast_inverse_sqrt_float32_unit import fisr_pkg::*; (
  input logic        clk,
  input logic        rst,
  fisr_in_if.sink    operand,
  fisr_out_if.source result
);

  localparam int YDEPTH = 3 * MUL_LAT + ADD_LAT;

  logic        en;
  logic        skid_valid;
  logic [31:0] skid_data;
  logic        out_valid;
  logic [31:0] out_data;
  logic [31:0] y0;
  logic [31:0] y_line [YDEPTH];
  pipe_ctl_t   c0, c1, c2, c3, c4;
  logic        v0, v1, v2, v3, v4;
  logic [31:0] xhalf, t1, t2, t3, r;

  assign en             = !skid_valid;
  assign operand.ready  = en;
  assign result.valid   = out_valid;
  assign result.result_bits = out_data;

  assign y0 = SEED_MAGIC - {operand.x_bits[31], operand.x_bits[31:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      y_line[0] <= y0;
      for (int i = 1; i < YDEPTH; i++) y_line[i] <= y_line[i-1];
    end
  end

  assign c0 = '{en: en, valid: operand.valid && en};
  assign c1 = '{en: en, valid: v0};
  assign c2 = '{en: en, valid: v1};
  assign c3 = '{en: en, valid: v2};
  assign c4 = '{en: en, valid: v3};

  fisr_fmul u_half (.clk, .rst, .ctl(c0), .a(HALF_BITS), .b(operand.x_bits),
                    .valid(v0), .res(xhalf));
  fisr_fmul u_m1 (.clk, .rst, .ctl(c1), .a(xhalf), .b(y_line[MUL_LAT-1]),
                  .valid(v1), .res(t1));
  fisr_fmul u_m2 (.clk, .rst, .ctl(c2), .a(t1), .b(y_line[2*MUL_LAT-1]),
                  .valid(v2), .res(t2));
  fisr_fadd u_sub (.clk, .rst, .ctl(c3), .a(THREEHALF_BITS), .b({~t2[31], t2[30:0]}),
                   .valid(v3), .res(t3));
  fisr_fmul u_m3 (.clk, .rst, .ctl(c4), .a(y_line[YDEPTH-1]), .b(t3),
                  .valid(v4), .res(r));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) skid_valid <= 1'b0;
    end else if (v4) begin
      if (!out_valid || result.ready) out_valid <= 1'b1;
      else skid_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result.ready) out_data <= skid_data;
    end else if (v4) begin
      if (!out_valid || result.ready) out_data <= r;
      else skid_data <= r;
    end
  end

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output register is empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v4) && $stable(r))
    else $error("pipeline moved during stall");

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !result.ready && v4))
    else $error("skid filled without a blocked output");

endmodule
